[rtl/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, codes and helpers of the link table best-select block.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int NUM_IFACES = 64;
  localparam int IDX_W      = $clog2(NUM_IFACES);

  typedef logic [IDX_W-1:0] slot_t;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_PARAM = 2'd2,
    REQ_KIND  = 2'd3
  } req_t;

  // address family of an event
  localparam logic [1:0] AF_IPV4 = 2'd0;
  localparam logic [1:0] AF_IPV6 = 2'd1;

  // family state of a table entry
  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V4   = 2'd1;
  localparam logic [1:0] FAM_V6   = 2'd2;
  localparam logic [1:0] FAM_BOTH = 2'd3;

  // learned link kinds
  localparam logic [2:0] KIND_OTHER    = 3'd0;
  localparam logic [2:0] KIND_ETHERNET = 3'd1;
  localparam logic [2:0] KIND_WIFI     = 3'd2;
  localparam logic [2:0] KIND_LOOPBACK = 3'd3;
  localparam logic [2:0] KIND_VIRTUAL  = 3'd4;
  localparam logic [2:0] KIND_TUNNEL   = 3'd5;

  // reported kind of the selection
  localparam logic [1:0] BK_OTHER = 2'd0;
  localparam logic [1:0] BK_ETH   = 2'd1;
  localparam logic [1:0] BK_WIFI  = 2'd2;

  // event status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic idle;   // take a new word
    logic upd;    // apply the event to the addressed entry
    logic scan;   // issue one table read of the scan
    logic fin;    // commit selection and load the result word
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

  function automatic logic [1:0] kind_rank(input logic [2:0] k);
    logic [1:0] r;
    r = 2'd0;
    if (k == KIND_ETHERNET) r = 2'd2;
    else if (k == KIND_WIFI) r = 2'd1;
    return r;
  endfunction

  function automatic logic [1:0] kind_code(input logic [2:0] k);
    logic [1:0] c;
    c = BK_OTHER;
    if (k == KIND_ETHERNET) c = BK_ETH;
    else if (k == KIND_WIFI) c = BK_WIFI;
    return c;
  endfunction

  function automatic logic kind_purged(input logic [2:0] k);
    return (k == KIND_LOOPBACK) || (k == KIND_VIRTUAL) || (k == KIND_TUNNEL);
  endfunction

endpackage

[rtl/lts_if.sv]
// ----------------------------------------------------------------------------
// lts_req_if / lts_res_if
// Valid/ready channels carrying event words and selection result words.
// ----------------------------------------------------------------------------
interface lts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] if_index;
  logic [1:0] addr_family;
  logic       connected;
  logic       reachable;
  logic [2:0] link_kind;

  modport source (output valid, req_type, if_index, addr_family, connected,
                  reachable, link_kind, input ready);
  modport sink   (input valid, req_type, if_index, addr_family, connected,
                  reachable, link_kind, output ready);
endinterface

interface lts_res_if;
  logic       valid;
  logic       ready;
  logic       best_valid;
  logic [5:0] sel_index;
  logic [1:0] best_kind;
  logic [1:0] best_families;
  logic       changed;
  logic [1:0] status;

  modport source (output valid, best_valid, sel_index, best_kind, best_families,
                  changed, status, input ready);
  modport sink   (input valid, best_valid, sel_index, best_kind, best_families,
                  changed, status, output ready);
endinterface

[rtl/lts_ctrl.sv]
// ----------------------------------------------------------------------------
// lts_ctrl
// Sequencer: read entry, update, scan the table, commit and emit the result.
// ----------------------------------------------------------------------------
module lts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lts_pkg::stat_t stat,
  output lts_pkg::cmd_t  cmd
);
  import lts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/lts_datapath.sv]
// ----------------------------------------------------------------------------
// lts_datapath
// Entry table (presence flops plus family and kind memories), event update,
// purge-and-select scan and the result register.
// ----------------------------------------------------------------------------
module lts_datapath (
  input  logic           clk,
  input  logic           rst,
  input  lts_pkg::cmd_t  cmd,
  output lts_pkg::stat_t stat,
  lts_req_if.sink        req,
  lts_res_if.source      res
);
  import lts_pkg::*;

  typedef struct packed {
    logic       p;
    logic [1:0] f;
    logic [1:0] st;
  } ent_t;

  function automatic logic [1:0] fam_state(input logic [1:0] af);
    logic [1:0] r;
    r = FAM_NONE;
    if (af == AF_IPV4) r = FAM_V4;
    else if (af == AF_IPV6) r = FAM_V6;
    return r;
  endfunction

  function automatic ent_t do_add(input ent_t e, input logic [1:0] af, input logic ok);
    ent_t r;
    r = e;
    if (ok) begin
      if (af == AF_IPV4 && e.p && e.f == FAM_V6) begin
        r.f = FAM_BOTH;
      end else if (af == AF_IPV6 && e.p && e.f == FAM_V4) begin
        r.f = FAM_BOTH;
      end else begin
        r.p = 1'b1;
        r.f = fam_state(af);
      end
    end
    return r;
  endfunction

  function automatic ent_t do_del(input ent_t e, input logic [1:0] af);
    ent_t       r;
    logic [1:0] own;
    logic [1:0] other;
    r     = e;
    own   = (af == AF_IPV4) ? FAM_V4 : FAM_V6;
    other = (af == AF_IPV4) ? FAM_V6 : FAM_V4;
    if (!e.p) begin
      r.st = ST_ABSENT;
    end else if (af == AF_IPV4 || af == AF_IPV6) begin
      if (e.f == own) begin
        r.p = 1'b0;
        r.f = FAM_NONE;
      end else if (e.f == FAM_BOTH) begin
        r.f = other;
      end else begin
        r.st = ST_MISMATCH;
      end
    end
    return r;
  endfunction

  // latched event word
  req_t       r_type;
  logic [5:0] r_idx;
  logic [1:0] r_fam;
  logic       r_conn;
  logic       r_reach;
  logic [2:0] r_kind;
  logic [1:0] r_st;

  // table
  logic [NUM_IFACES-1:0] present;
  logic [NUM_IFACES-1:0] kind_vld;
  logic [1:0]            fam_mem  [NUM_IFACES];
  logic [2:0]            kind_mem [NUM_IFACES];

  // read port
  slot_t      rd_addr;
  slot_t      a_q;
  logic       a_vld;
  logic [1:0] fam_q;
  logic [2:0] kind_q;
  logic       kv_q;

  slot_t ix;
  logic  in_rng;
  ent_t  e0, e1;

  // scan
  slot_t      cnt;
  logic [2:0] k_eff;
  logic       p_s;
  logic       purge;
  logic       eff;
  logic [1:0] rank;
  logic       found;
  slot_t      best;
  logic [1:0] best_rank;
  logic [1:0] best_kind;
  logic [1:0] best_fam;

  // selection state and result word
  logic  cur_valid;
  slot_t cur_slot;
  logic  first_done;
  logic  chg;
  logic  out_valid;
  logic  o_best_valid;
  logic [5:0] o_sel_index;
  logic [1:0] o_best_kind;
  logic [1:0] o_best_fam;
  logic  o_changed;
  logic [1:0] o_status;

  assign req.ready = cmd.idle;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_type  <= req_t'(req.req_type);
      r_idx   <= req.if_index;
      r_fam   <= req.addr_family;
      r_conn  <= req.connected;
      r_reach <= req.reachable;
      r_kind  <= req.link_kind;
    end
  end

  assign ix     = slot_t'(r_idx);
  assign in_rng = (32'(r_idx) < 32'(NUM_IFACES));

  // ---- event update ----
  always_comb begin
    e0.p  = present[ix];
    e0.f  = present[ix] ? fam_q : FAM_NONE;
    e0.st = ST_OK;
    e1    = e0;
    case (r_type)
      REQ_ADD: begin
        if (r_conn) e1 = do_add(e0, r_fam, r_reach);
      end
      REQ_DEL: begin
        e1 = do_del(e0, r_fam);
      end
      REQ_PARAM: begin
        if (e0.p && r_conn) begin
          if (e0.f == FAM_V4 && r_fam == AF_IPV6) e1.f = FAM_BOTH;
          else if (e0.f == FAM_V6 && r_fam == AF_IPV4) e1.f = FAM_BOTH;
        end
        if (r_conn) begin
          if (!e0.p) e1 = do_add(e1, r_fam, r_reach);
        end else if (e0.p) begin
          e1 = do_del(e1, r_fam);
        end
      end
      default: e1 = e0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) r_st <= in_rng ? e1.st : ST_OK;
  end

  // ---- memories: one read port, one write port ----
  assign rd_addr = cmd.scan ? cnt : ix;

  always_ff @(posedge clk) begin
    fam_q  <= fam_mem[rd_addr];
    kind_q <= kind_mem[rd_addr];
    kv_q   <= kind_vld[rd_addr];
    a_q    <= rd_addr;
    if (cmd.upd && in_rng) fam_mem[ix] <= e1.f;
    if (cmd.upd && in_rng && r_type == REQ_KIND) kind_mem[ix] <= r_kind;
  end

  // presence and kind-written bits double as the table's reset
  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      kind_vld <= '0;
      a_vld    <= 1'b0;
    end else begin
      a_vld <= cmd.scan;
      if (cmd.upd && in_rng) present[ix] <= e1.p;
      if (cmd.upd && in_rng && r_type == REQ_KIND) kind_vld[ix] <= 1'b1;
      if (a_vld && purge) present[a_q] <= 1'b0;
    end
  end

  // ---- purge and select, one entry per cycle ----
  assign k_eff = kv_q ? kind_q : KIND_OTHER;
  assign p_s   = present[a_q];
  assign purge = p_s && kind_purged(k_eff);
  assign eff   = p_s && !purge;
  assign rank  = kind_rank(k_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      found <= 1'b0;
    end else if (cmd.upd) begin
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.scan) cnt <= cnt + 1'b1;
      if (a_vld && eff && (!found || rank > best_rank)) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld && eff && (!found || rank > best_rank)) begin
      best      <= a_q;
      best_rank <= rank;
      best_kind <= kind_code(k_eff);
      best_fam  <= fam_q;
    end
  end

  assign stat.scan_last = (cnt == slot_t'(NUM_IFACES - 1));
  assign stat.out_free  = !out_valid || res.ready;

  // ---- commit and result word ----
  assign chg = found ? !(cur_valid && cur_slot == best && first_done)
                     : !(!cur_valid && first_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      cur_slot   <= '0;
      first_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid <= 1'b1;
        if (chg) begin
          cur_valid  <= found;
          cur_slot   <= found ? best : '0;
          first_done <= 1'b1;
        end
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      o_best_valid <= found;
      o_sel_index  <= found ? 6'(best) : 6'd0;
      o_best_kind  <= found ? best_kind : BK_OTHER;
      o_best_fam   <= found ? best_fam : FAM_NONE;
      o_changed    <= chg;
      o_status     <= r_st;
    end
  end

  assign res.valid         = out_valid;
  assign res.best_valid    = o_best_valid;
  assign res.sel_index     = o_sel_index;
  assign res.best_kind     = o_best_kind;
  assign res.best_families = o_best_fam;
  assign res.changed       = o_changed;
  assign res.status        = o_status;

endmodule

[rtl/link_table_best_select.sv]
// ----------------------------------------------------------------------------
// link_table_best_select
// Interface table with add/delete/parameter/kind events, purge of loopback,
// virtual and tunnel links, and selection of the best remaining link.
// ----------------------------------------------------------------------------
// Per word: read the entry, update it, scan all NUM_IFACES entries, drain, then
// commit into the result word. One event word at a time: a new word is taken
//   only in idle, after the commit. The table scan reads one entry per cycle
//   through the single read port of the entry memories.
// The result register lets the next word in while a result waits.
// Reset: synchronous; clears presence and kind-written bits at once, no sweep.
// ----------------------------------------------------------------------------
module link_table_best_select (
  input logic       clk,
  input logic       rst,
  lts_req_if.sink   req,
  lts_res_if.source res
);
  import lts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  lts_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .res  (res)
  );

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("word accepted while previous event in progress");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");

  a_fin_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> stat.out_free)
    else $error("result loaded over an untaken word");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.best_valid) |->
      (res.sel_index == 6'd0 && res.best_kind == BK_OTHER &&
       res.best_families == FAM_NONE))
    else $error("fields not cleared with no selection");

endmodule
